// ===== rtl/core/skvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Command and status codes, port field widths and the request and result
// structures shared by the table's modules and interfaces.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int TOTAL_W  = 5;

	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  found_value;
		logic [POS_W-1:0]    position;
		logic [TOTAL_W-1:0]  entry_total;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/skvt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table channels
// Valid/ready request and result channels; a transaction completes on a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface skvt_req_if;
	import skvt_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [KEY_W-1:0]   key;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output command, output key, output value, input ready);
	modport sink (input valid, input command, input key, input value, output ready);
endinterface

interface skvt_rsp_if;
	import skvt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  found_value;
	logic [POS_W-1:0]    position;
	logic [TOTAL_W-1:0]  entry_total;

	modport source (output valid, output status, output found_value, output position,
		output entry_total, input ready);
	modport sink (input valid, input status, input found_value, input position,
		input entry_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/skvt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/skvt_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table sequencer
// Binary search over the key memory, then an entry-by-entry shift that opens
// or closes a slot, all under one small state machine.
// ----------------------------------------------------------------------------
module skvt_seq #(
	parameter int CAPACITY    = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire skvt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output skvt_pkg::rsp_t     rsp
);
	import skvt_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_ACT   = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]             state_q;
	logic [CW-1:0]          count_q;
	logic                   pend_q;

	logic [CMD_W-1:0]       cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]          lo_q;
	logic [CW-1:0]          hi_q;
	logic [CW-1:0]          mid_q;
	logic [CW-1:0]          idx_q;
	logic                   hit_q;
	logic [VALUE_WIDTH-1:0] fv_hit_q;
	logic                   up_q;
	logic [CW-1:0]          rem_q;
	logic [IW-1:0]          src_q;
	logic [IW-1:0]          pend_src_q;
	logic [STATUS_W-1:0]    status_q;
	logic [VALUE_WIDTH-1:0] fv_q;
	logic [CW-1:0]          pos_q;

	logic [KEY_WIDTH+31:0]   key_wide;
	logic [VALUE_WIDTH+31:0] val_wide;
	logic [VALUE_WIDTH+31:0] fv_wide;
	logic [CW+3:0]           pos_wide;
	logic [CW+4:0]           total_wide;

	logic [CW-1:0]          mid_c;
	logic [CW-1:0]          cnt_m1;
	logic [CW-1:0]          idx_p1;
	logic                   full_c;
	logic                   grow_c;
	logic                   shrink_c;

	logic                   k_we;
	logic                   v_we;
	logic [IW-1:0]          waddr;
	logic [KEY_WIDTH-1:0]   wkey;
	logic [VALUE_WIDTH-1:0] wval;
	logic                   re;
	logic [IW-1:0]          raddr;
	logic [KEY_WIDTH-1:0]   key_rdata;
	logic [VALUE_WIDTH-1:0] val_rdata;

	assign key_wide = {{KEY_WIDTH{1'b0}}, req.key};
	assign val_wide = {{VALUE_WIDTH{1'b0}}, req.value};

	assign mid_c  = lo_q + ((hi_q - lo_q) >> 1);
	assign cnt_m1 = count_q - CW'(1);
	assign idx_p1 = idx_q + CW'(1);
	assign full_c = (count_q >= CAP_C);

	// A miss on insert or set opens a slot unless the table is full; a hit on remove closes one.
	assign grow_c   = !hit_q && !full_c && (cmd_q == CMD_INSERT || cmd_q == CMD_SET);
	assign shrink_c = hit_q && (cmd_q == CMD_REMOVE);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_DONE);

	assign fv_wide    = {32'b0, fv_q};
	assign pos_wide   = {4'b0, pos_q};
	assign total_wide = {5'b0, count_q};

	always_comb begin
		rsp.status      = status_q;
		rsp.found_value = fv_wide[VALUE_W-1:0];
		rsp.position    = pos_wide[POS_W-1:0];
		rsp.entry_total = total_wide[TOTAL_W-1:0];
	end

	// Memory port control.
	always_comb begin
		k_we  = 1'b0;
		v_we  = 1'b0;
		waddr = idx_q[IW-1:0];
		wkey  = key_q;
		wval  = val_q;
		re    = 1'b0;
		raddr = mid_c[IW-1:0];
		case (state_q)
			S_PROBE: begin
				re = (lo_q < hi_q);
			end
			S_ACT: begin
				v_we = hit_q && (cmd_q == CMD_SET);
			end
			S_SHIFT: begin
				// The entry read last cycle is written one slot over.
				if (pend_q) begin
					k_we  = 1'b1;
					v_we  = 1'b1;
					waddr = up_q ? (pend_src_q + IW'(1)) : (pend_src_q - IW'(1));
					wkey  = key_rdata;
					wval  = val_rdata;
				end
				re    = (rem_q != '0);
				raddr = src_q;
			end
			S_PUT: begin
				k_we = up_q;
				v_we = up_q;
			end
			default: begin
			end
		endcase
	end

	skvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (waddr),
		.wdata (wkey),
		.re    (re),
		.raddr (raddr),
		.rdata (key_rdata)
	);

	skvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (waddr),
		.wdata (wval),
		.re    (re),
		.raddr (raddr),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= (lo_q < hi_q) ? S_CMP : S_ACT;
				end
				S_CMP: begin
					state_q <= (key_rdata == key_q) ? S_ACT : S_PROBE;
				end
				S_ACT: begin
					pend_q  <= 1'b0;
					state_q <= (grow_c || shrink_c) ? S_SHIFT : S_DONE;
				end
				S_SHIFT: begin
					pend_q <= (rem_q != '0);
					if (rem_q == '0 && !pend_q) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= up_q ? (count_q + CW'(1)) : cnt_m1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_q <= req.command;
					key_q <= key_wide[KEY_WIDTH-1:0];
					val_q <= val_wide[VALUE_WIDTH-1:0];
					lo_q  <= '0;
					hi_q  <= count_q;
					hit_q <= 1'b0;
				end
			end
			S_PROBE: begin
				if (lo_q < hi_q) begin
					mid_q <= mid_c;
				end else begin
					idx_q <= lo_q;
					hit_q <= 1'b0;
				end
			end
			S_CMP: begin
				if (key_rdata == key_q) begin
					hit_q    <= 1'b1;
					idx_q    <= mid_q;
					fv_hit_q <= val_rdata;
				end else if (key_rdata > key_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + CW'(1);
				end
			end
			S_ACT: begin
				fv_q  <= '0;
				up_q  <= grow_c;
				pos_q <= idx_q;
				case (cmd_q)
					CMD_FIND: begin
						status_q <= hit_q ? ST_OK : ST_MISSING;
						if (hit_q) begin
							fv_q <= fv_hit_q;
						end else begin
							pos_q <= '0;
						end
					end
					CMD_INSERT, CMD_SET: begin
						if (hit_q) begin
							status_q <= (cmd_q == CMD_INSERT) ? ST_PRESENT : ST_OK;
						end else if (full_c) begin
							status_q <= ST_FULL;
							pos_q    <= '0;
						end else begin
							status_q <= ST_OK;
						end
					end
					default: begin
						status_q <= hit_q ? ST_OK : ST_MISSING;
						if (!hit_q) begin
							pos_q <= '0;
						end
					end
				endcase
				if (grow_c) begin
					rem_q <= count_q - idx_q;
					src_q <= cnt_m1[IW-1:0];
				end else begin
					rem_q <= cnt_m1 - idx_q;
					src_q <= idx_p1[IW-1:0];
				end
			end
			S_SHIFT: begin
				if (rem_q != '0) begin
					pend_src_q <= src_q;
					src_q      <= up_q ? (src_q - IW'(1)) : (src_q + IW'(1));
					rem_q      <= rem_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/sorted_key_value_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table
// Holds up to CAPACITY key/value pairs in ascending unsigned key order and
// serves find, insert, set and remove requests.
// ----------------------------------------------------------------------------
// Usage:
//   request carries command, key and value; result returns status,
//   found_value, position and entry_total, one result per request.
//   The block takes one request at a time: request.ready is high only while
//   the sequencer is idle. A binary search takes up to ceil(log2(n+1)) probes
//   for n held pairs, each probe a memory read, then a compare. Insert, set of
//   a new key and remove then move the later entries one slot over, one entry
//   per cycle through the single memory write port. The sequencer returns to
//   idle as its result is loaded into the output register.
//   The result sits in an output register, so a new request is accepted
//   while the previous result waits; a stalled receiver only holds back the
//   request after that. Reset empties the table (the pair count is zeroed);
//   memory contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
	parameter int CAPACITY    = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	skvt_req_if.sink  request,
	skvt_rsp_if.source result
);
	import skvt_pkg::*;

	req_t req_s;
	rsp_t seq_rsp;
	rsp_t res_q;
	logic res_valid_q;
	logic seq_rsp_valid;
	logic seq_rsp_ready;

	always_comb begin
		req_s.command = request.command;
		req_s.key     = request.key;
		req_s.value   = request.value;
	end

	skvt_seq #(
		.CAPACITY    (CAPACITY),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.req       (req_s),
		.rsp_valid (seq_rsp_valid),
		.rsp_ready (seq_rsp_ready),
		.rsp       (seq_rsp)
	);

	// The output register is free when empty or being drained this cycle.
	assign seq_rsp_ready = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (seq_rsp_ready) begin
			res_valid_q <= seq_rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_rsp_ready && seq_rsp_valid) begin
			res_q <= seq_rsp;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.status      = res_q.status;
	assign result.found_value = res_q.found_value;
	assign result.position    = res_q.position;
	assign result.entry_total = res_q.entry_total;
endmodule
`default_nettype wire

// ===== rtl/core/skvt_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table checker
// Port-level assertions on the request and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
module skvt_chk #(
	parameter int CAPACITY = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [skvt_pkg::STATUS_W-1:0] status,
	input wire logic [skvt_pkg::VALUE_W-1:0]  found_value,
	input wire logic [skvt_pkg::POS_W-1:0]    position,
	input wire logic [skvt_pkg::TOTAL_W-1:0]  entry_total
);
	import skvt_pkg::*;

	localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(CAPACITY);

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn while stalled");

	// The table works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while the previous one is in progress");

	// Only a successful find returns a value.
	a_value_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> found_value == '0)
		else $error("nonzero value on a failed request");

	// A refused insert or set reports a full table at position zero.
	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> entry_total == FULL_TOTAL && position == '0)
		else $error("table full reported with wrong total or position");
endmodule

bind sorted_key_value_table skvt_chk #(.CAPACITY(CAPACITY)) u_skvt_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.rsp_valid   (result.valid),
	.rsp_ready   (result.ready),
	.status      (result.status),
	.found_value (result.found_value),
	.position    (result.position),
	.entry_total (result.entry_total)
);
`default_nettype wire

// ===== dv/sorted_key_value_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key/value table regression
// Drives find, insert, set and remove requests through the request channel
// with random gaps, stalls the result channel at random, and checks every
// result against a behavioral table kept in step with accepted requests.
// ----------------------------------------------------------------------------
module sorted_key_value_table_test;
	import skvt_pkg::*;

	localparam int TABLE_DEPTH    = 16;
	localparam int KEY_POOL_SIZE  = 20;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int REPORT_LIMIT   = 50;

	logic clk;
	logic arst_n;

	skvt_req_if request_ch();
	skvt_rsp_if result_ch();

	sorted_key_value_table #(
		.CAPACITY(TABLE_DEPTH),
		.KEY_WIDTH(KEY_W),
		.VALUE_WIDTH(VALUE_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.request(request_ch),
		.result(result_ch)
	);

	// Behavioral copy of the table contents.
	logic [KEY_W-1:0]   held_key [TABLE_DEPTH];
	logic [VALUE_W-1:0] held_value [TABLE_DEPTH];
	int unsigned        held;

	rsp_t               pending_results[$];
	rsp_t               oldest_result;
	logic [KEY_W-1:0]   key_pool [KEY_POOL_SIZE];
	int unsigned        mismatch_count;
	int unsigned        idle_cycles;
	bit                 no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the result of one request and updates the table copy.
	function automatic rsp_t apply_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
		logic [VALUE_W-1:0] v);
		rsp_t        r;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int unsigned j;
		bit          hit;
		r = '0;
		r.status = ST_OK;
		lo = 0;
		hi = held;
		hit = 1'b0;
		while (lo < hi && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (held_key[mid] == k) begin
				hit = 1'b1;
				lo = mid;
			end else if (held_key[mid] > k) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		case (cmd)
			CMD_FIND: begin
				if (hit) begin
					r.found_value = held_value[lo];
					r.position = lo[POS_W-1:0];
				end else begin
					r.status = ST_MISSING;
				end
			end
			CMD_INSERT, CMD_SET: begin
				if (hit) begin
					if (cmd == CMD_INSERT)
						r.status = ST_PRESENT;
					else
						held_value[lo] = v;
					r.position = lo[POS_W-1:0];
				end else if (held >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (j = held; j > lo; j--) begin
						held_key[j] = held_key[j-1];
						held_value[j] = held_value[j-1];
					end
					held_key[lo] = k;
					held_value[lo] = v;
					held++;
					r.position = lo[POS_W-1:0];
				end
			end
			default: begin
				if (hit) begin
					for (j = lo; j + 1 < held; j++) begin
						held_key[j] = held_key[j+1];
						held_value[j] = held_value[j+1];
					end
					held--;
					r.position = lo[POS_W-1:0];
				end else begin
					r.status = ST_MISSING;
				end
			end
		endcase
		r.entry_total = held[TOTAL_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// Sends one request after a random gap and records its expected result.
	task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
		logic [VALUE_W-1:0] v);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.command <= cmd;
		request_ch.key <= k;
		request_ch.value <= v;
		do @(posedge clk); while (!request_ch.ready);
		pending_results.push_back(apply_request(cmd, k, v));
	endtask

	task automatic wait_for_results();
		request_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
			4, 5, 6: k = (held != 0) ? held_key[$urandom_range(0, held - 1)]
				: key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
			7: begin
				// Neighbors of held keys probe the search boundaries.
				k = (held != 0) ? held_key[$urandom_range(0, held - 1)] : '0;
				k = $urandom_range(0, 1) ? k + KEY_W'(1) : k - KEY_W'(1);
			end
			8: k = $urandom;
			default: k = $urandom_range(0, 1) ? '1 : '0;
		endcase
		return k;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_basic_commands();
		send_request(CMD_FIND, 32'h0000_0000, 32'h0);
		send_request(CMD_REMOVE, 32'h0000_0005, 32'h0);
		send_request(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
		send_request(CMD_INSERT, 32'h0000_0000, 32'h1111_1111);
		send_request(CMD_SET, 32'hFFFF_FFFF, 32'h1234_5678);
		send_request(CMD_SET, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
		send_request(CMD_FIND, 32'h0000_0000, 32'h0);
		send_request(CMD_FIND, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_FIND, 32'h8000_0001, 32'h0);
		send_request(CMD_FIND, 32'h7FFF_FFFF, 32'h0);
		send_request(CMD_REMOVE, 32'h8000_0000, 32'h0);
		send_request(CMD_REMOVE, 32'h0000_0000, 32'h0);
		send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_REMOVE, 32'h8000_0000, 32'h0);
		send_request(CMD_FIND, 32'h7FFF_FFFF, 32'h0);
		send_request(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0);
		wait_for_results();
	endtask

	// Descending keys land at slot zero each time, so every insert shifts the
	// whole table.
	task automatic test_full_table();
		int unsigned n;
		for (n = 0; n < TABLE_DEPTH; n++)
			send_request(CMD_INSERT, 32'h1000 + (TABLE_DEPTH - 1 - n) * 16, pick_value());
		send_request(CMD_INSERT, 32'h0000_0000, pick_value());
		send_request(CMD_SET, 32'hFFFF_FFFF, pick_value());
		send_request(CMD_SET, 32'h0000_1000, pick_value());
		send_request(CMD_INSERT, 32'h0000_10F0, pick_value());
		send_request(CMD_FIND, 32'h0000_1008, pick_value());
		send_request(CMD_FIND, 32'h0000_10F0, pick_value());
		wait_for_results();
		while (held != 0)
			send_request(CMD_REMOVE, held_key[0], pick_value());
	endtask

	// Alternates between filling the table and emptying it, with random keys.
	task automatic test_random_churn(int unsigned items);
		int unsigned      n;
		int unsigned      roll;
		bit               growing;
		logic [CMD_W-1:0] cmd;
		growing = 1'b1;
		for (n = 0; n < items; n++) begin
			if (n % 150 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (n % 400 == 399)
				wait_for_results();
			if (held >= TABLE_DEPTH && $urandom_range(0, 7) == 0)
				growing = 1'b0;
			else if (held == 0)
				growing = 1'b1;
			roll = $urandom_range(0, 99);
			if (growing)
				cmd = (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_SET
					: (roll < 85) ? CMD_FIND : CMD_REMOVE;
			else
				cmd = (roll < 50) ? CMD_REMOVE : (roll < 75) ? CMD_FIND
					: (roll < 90) ? CMD_INSERT : CMD_SET;
			send_request(cmd, pick_key(), pick_value());
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random_noise(int unsigned items);
		int unsigned      n;
		logic [KEY_W-1:0] k;
		for (n = 0; n < items; n++) begin
			k = $urandom_range(0, 1) ? pick_key() : $urandom;
			send_request(CMD_W'($urandom_range(0, 3)), k, $urandom);
		end
	endtask

	// Result side: random stall before each transaction.
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'h0, 32'h0);
			end else begin
				oldest_result = pending_results.pop_front();
				if (result_ch.status !== oldest_result.status)
					report_mismatch("status", 32'(result_ch.status),
						32'(oldest_result.status));
				if (result_ch.found_value !== oldest_result.found_value)
					report_mismatch("found_value", result_ch.found_value,
						oldest_result.found_value);
				if (result_ch.position !== oldest_result.position)
					report_mismatch("position", 32'(result_ch.position),
						32'(oldest_result.position));
				if (result_ch.entry_total !== oldest_result.entry_total)
					report_mismatch("entry_total", 32'(result_ch.entry_total),
						32'(oldest_result.entry_total));
			end
		end
	end

	// Watchdog: ends the run when no transaction completes for too long.
	always @(posedge clk) begin
		if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sorted_key_value_table regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned i;
		arst_n = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.command = CMD_FIND;
		request_ch.key = '0;
		request_ch.value = '0;
		result_ch.ready = 1'b0;
		held = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'h8000_0000;
		for (i = 3; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_full_table();
		test_random_churn(1450);
		test_random_noise(220);

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("sorted_key_value_table regression: pass");
		else
			$display("sorted_key_value_table regression: fail");
		$finish;
	end

endmodule
